@@ sv/mmss_pkg.sv @@
package mmss_pkg;

  localparam int unsigned FRAME_BYTES = 18;
  localparam int unsigned IDX_W       = $clog2(FRAME_BYTES);

  localparam logic [7:0]  CMD_DATA    = 8'h40;
  localparam logic [7:0]  CMD_ADDR    = 8'hc0;
  localparam logic [7:0]  DOT_BIT     = 8'h80;
  localparam logic [12:0] MAX_SECONDS = 13'd5999;

  // floor(x/60) = (x*MIN_RECIP)>>20 for x <= 5999
  localparam logic [14:0] MIN_RECIP   = 15'd17477;
  localparam int unsigned MIN_SHIFT   = 20;
  // floor(x/10) = (x*DIV10_RECIP)>>11 for x < 1029
  localparam logic [7:0]  DIV10_RECIP = 8'd205;
  localparam int unsigned DIV10_SHIFT = 11;

  localparam logic [IDX_W-1:0] IDX_CMD_DATA = IDX_W'(0);
  localparam logic [IDX_W-1:0] IDX_CMD_ADDR = IDX_W'(1);
  localparam logic [IDX_W-1:0] IDX_MIN_TENS = IDX_W'(8);
  localparam logic [IDX_W-1:0] IDX_MIN_UNIT = IDX_W'(10);
  localparam logic [IDX_W-1:0] IDX_SEC_TENS = IDX_W'(12);
  localparam logic [IDX_W-1:0] IDX_SEC_UNIT = IDX_W'(14);
  localparam logic [IDX_W-1:0] IDX_FIRST_LED = IDX_W'(3);
  localparam logic [IDX_W-1:0] IDX_LAST     = IDX_W'(FRAME_BYTES - 1);

  typedef struct packed {
    logic [3:0] min_tens;
    logic [6:0] mins;
    logic [2:0] sec_tens;
    logic [5:0] sec_part;
    logic [7:0] leds;
  } digits_t;

  function automatic logic [7:0] seg_code(input logic [3:0] digit);
    logic [7:0] code;
    unique case (digit)
      4'd0:    code = 8'h3f;
      4'd1:    code = 8'h06;
      4'd2:    code = 8'h9b;
      4'd3:    code = 8'h8f;
      4'd4:    code = 8'hc6;
      4'd5:    code = 8'h6d;
      4'd6:    code = 8'h7d;
      4'd7:    code = 8'h07;
      4'd8:    code = 8'h7f;
      4'd9:    code = 8'hcf;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

@@ sv/mmss_led_display_frame_core.sv @@
// channel   dir  tdata                                        tlast
// s_axis    in   [12:0] total_seconds, [20:13] led_bits       -
// m_axis    out  [7:0] frame_byte                             last frame byte
//
// Each input transaction produces 18 output bytes, one per cycle unless stalled.
// The byte sequencer sets the rate; new items wait in the front stages and queue.
// Path: 3 front stages for the digit split, then the queue and output register.
// Input and output stall independently; the queue holds QUEUE_DEPTH split items.
// Asynchronous active-low reset clears all valid flags and the byte counter.
module mmss_led_display_frame_core
  import mmss_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [12:0] total_seconds, [20:13] led_bits
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] frame_byte
  output logic        m_axis_tlast
);

  logic    fr_valid, fr_ready;
  digits_t fr_digits;
  logic    q_valid, q_pop;
  digits_t q_digits;

  mmss_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .total_seconds_i (s_axis_tdata[12:0]),
    .led_bits_i      (s_axis_tdata[20:13]),
    .out_valid_o     (fr_valid),
    .out_ready_i     (fr_ready),
    .out_digits_o    (fr_digits)
  );

  mmss_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i,
    .rst_ni,
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  (fr_digits),
    .pop_valid_o  (q_valid),
    .pop_i        (q_pop),
    .pop_data_o   (q_digits)
  );

  mmss_back u_back (
    .clk_i,
    .rst_ni,
    .q_valid_i   (q_valid),
    .q_digits_i  (q_digits),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

@@ sv/mmss_front.sv @@
module mmss_front
  import mmss_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [12:0] total_seconds_i,
  input  logic [7:0] led_bits_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output digits_t    out_digits_o
);

  logic        v1_q, v2_q, v3_q;
  logic        rdy1, rdy2, rdy3;
  logic [12:0] secs1_q, secs2_q;
  logic [7:0]  leds1_q, leds2_q;
  logic [6:0]  mins2_q;
  digits_t     dig3_q;

  logic [27:0] min_prod;
  logic [12:0] mins_x60;
  logic [5:0]  sec_part;
  logic [14:0] mt_prod;
  logic [13:0] st_prod;

  assign rdy3 = !v3_q || out_ready_i;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  assign min_prod = 28'(secs1_q) * 28'(MIN_RECIP);
  assign mins_x60 = (13'(mins2_q) << 6) - (13'(mins2_q) << 2);
  assign sec_part = 6'(secs2_q - mins_x60);
  assign mt_prod  = 15'(mins2_q) * 15'(DIV10_RECIP);
  assign st_prod  = 14'(sec_part) * 14'(DIV10_RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      secs1_q <= (total_seconds_i > MAX_SECONDS) ? MAX_SECONDS : total_seconds_i;
      leds1_q <= led_bits_i;
    end
    if (rdy2 && v1_q) begin
      secs2_q <= secs1_q;
      leds2_q <= leds1_q;
      mins2_q <= min_prod[MIN_SHIFT +: 7];
    end
    if (rdy3 && v2_q) begin
      dig3_q.min_tens <= mt_prod[DIV10_SHIFT +: 4];
      dig3_q.mins     <= mins2_q;
      dig3_q.sec_tens <= st_prod[DIV10_SHIFT +: 3];
      dig3_q.sec_part <= sec_part;
      dig3_q.leds     <= leds2_q;
    end
  end

  assign out_valid_o  = v3_q;
  assign out_digits_o = dig3_q;

endmodule

@@ sv/mmss_queue.sv @@
module mmss_queue
  import mmss_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_valid_i,
  output logic    push_ready_o,
  input  digits_t push_data_i,
  output logic    pop_valid_o,
  input  logic    pop_i,
  output digits_t pop_data_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  digits_t            mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_q, rd_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               push, pop;

  assign push_ready_o = (cnt_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_i && pop_valid_o;
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      if (pop)  rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      if (push && !pop)      cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_data_i;
  end

endmodule

@@ sv/mmss_back.sv @@
module mmss_back
  import mmss_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  digits_t    q_digits_i,
  output logic       q_pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  logic [IDX_W-1:0] idx_q, idx_d;
  logic             valid_q, valid_d;
  logic [7:0]       byte_q, byte_d;
  logic             last_q, last_d;
  logic             load, is_last;
  logic [3:0]       min_unit, sec_unit;
  logic [IDX_W-1:0] led_sel;

  assign min_unit = 4'(q_digits_i.mins - ((7'(q_digits_i.min_tens) << 3)
                                        + (7'(q_digits_i.min_tens) << 1)));
  assign sec_unit = 4'(q_digits_i.sec_part - ((6'(q_digits_i.sec_tens) << 3)
                                            + (6'(q_digits_i.sec_tens) << 1)));
  assign led_sel  = (idx_q - IDX_FIRST_LED) >> 1;

  assign load    = !valid_q || out_ready_i;
  assign is_last = (idx_q == IDX_LAST);
  assign q_pop_o = load && q_valid_i && is_last;

  always_comb begin
    priority if (idx_q == IDX_CMD_DATA) byte_d = CMD_DATA;
    else if (idx_q == IDX_CMD_ADDR)     byte_d = CMD_ADDR;
    else if (idx_q[0])                  byte_d = {7'b0, q_digits_i.leds[led_sel[2:0]]};
    else if (idx_q == IDX_MIN_TENS)     byte_d = seg_code(q_digits_i.min_tens);
    else if (idx_q == IDX_MIN_UNIT)
      byte_d = seg_code(min_unit) | (q_digits_i.sec_part[0] ? 8'h00 : DOT_BIT);
    else if (idx_q == IDX_SEC_TENS)     byte_d = seg_code({1'b0, q_digits_i.sec_tens});
    else if (idx_q == IDX_SEC_UNIT)     byte_d = seg_code(sec_unit);
    else                                byte_d = 8'h00;
  end

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    last_d  = is_last;
    if (load) begin
      valid_d = q_valid_i;
      if (q_valid_i) idx_d = is_last ? '0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && q_valid_i) begin
      byte_q <= byte_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;

endmodule

@@ sv/mmss_checker.sv @@
module mmss_checker
  import mmss_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tlast
);

  logic [IDX_W-1:0] pos_q;
  logic [3:0]       pend_q;
  logic             in_xfer, out_xfer, frame_done;

  assign in_xfer    = s_axis_tvalid && s_axis_tready;
  assign out_xfer   = m_axis_tvalid && m_axis_tready;
  assign frame_done = out_xfer && m_axis_tlast;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      pend_q <= '0;
    end else begin
      if (out_xfer) pos_q <= (pos_q == IDX_LAST) ? '0 : pos_q + 1'b1;
      if (in_xfer && !frame_done)      pend_q <= pend_q + 1'b1;
      else if (frame_done && !in_xfer) pend_q <= pend_q - 1'b1;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("output changed while stalled");

  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer |-> (m_axis_tlast == (pos_q == IDX_LAST)))
    else $error("tlast not on eighteenth byte");

  a_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && (pos_q == IDX_CMD_DATA || pos_q == IDX_CMD_ADDR) |->
      m_axis_tdata == ((pos_q == IDX_CMD_DATA) ? CMD_DATA : CMD_ADDR))
    else $error("bad frame header");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pend_q != '0)
    else $error("output without accepted input");

endmodule

bind mmss_led_display_frame_core mmss_checker u_mmss_checker (.*);

@@ bench/mmss_frame_checker.sv @@
module mmss_frame_checker
  import mmss_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [23:0] in_data_i,    // [12:0] total_seconds, [20:13] led_bits
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  out_data_i,   // [7:0] frame_byte
  input  logic        out_last_i,
  output int          errors_o,
  output int          pending_o
);

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last;
  } frame_beat_t;

  frame_beat_t frame_bytes_due[$];
  int          bytes_seen;

  function automatic logic [7:0] digit_segments(input int d);
    case (d)
      0:       return 8'h3f;
      1:       return 8'h06;
      2:       return 8'h9b;
      3:       return 8'h8f;
      4:       return 8'hc6;
      5:       return 8'h6d;
      6:       return 8'h7d;
      7:       return 8'h07;
      8:       return 8'h7f;
      default: return 8'hcf;
    endcase
  endfunction

  task automatic predict_frame(input logic [12:0] secs_in, input logic [7:0] leds);
    int          secs;
    int          mins;
    int          sec_part;
    int          slot;
    frame_beat_t beat;
    secs = secs_in;
    if (secs > MAX_SECONDS) secs = MAX_SECONDS;
    mins     = secs / 60;
    sec_part = secs % 60;
    for (int k = 0; k < FRAME_BYTES; k++) begin
      slot = k - 2;
      beat.last = (k == FRAME_BYTES - 1);
      if (k == 0) beat.frame_byte = CMD_DATA;
      else if (k == 1) beat.frame_byte = CMD_ADDR;
      else if (slot % 2 == 1) beat.frame_byte = {7'd0, leds[(slot - 1) / 2]};
      else if (slot == 6) beat.frame_byte = digit_segments(mins / 10);
      else if (slot == 8) begin
        beat.frame_byte = digit_segments(mins % 10);
        if (sec_part % 2 == 0) beat.frame_byte = beat.frame_byte | DOT_BIT;
      end
      else if (slot == 10) beat.frame_byte = digit_segments(sec_part / 10);
      else if (slot == 12) beat.frame_byte = digit_segments(sec_part % 10);
      else beat.frame_byte = 8'h00;
      frame_bytes_due.push_back(beat);
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    if (errors_o < 40)
      $display("mismatch at byte %0d: %s got 0x%0h expected 0x%0h", bytes_seen, what, got,
               want);
    errors_o = errors_o + 1;
  endtask

  initial begin
    errors_o  = 0;
    pending_o = 0;
    bytes_seen = 0;
  end

  always @(posedge clk_i) begin
    frame_beat_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) predict_frame(in_data_i[12:0], in_data_i[20:13]);
      if (out_valid_i && out_ready_i) begin
        if (frame_bytes_due.size() == 0) begin
          report_mismatch("unexpected transaction", out_data_i, 0);
        end else begin
          want = frame_bytes_due.pop_front();
          if (out_data_i !== want.frame_byte)
            report_mismatch("frame_byte", out_data_i, want.frame_byte);
          if (out_last_i !== want.last)
            report_mismatch("tlast", out_last_i, want.last);
        end
        bytes_seen = bytes_seen + 1;
      end
      pending_o = frame_bytes_due.size();
    end
  end

endmodule

@@ bench/tb_mmss_led_display_frame_core.sv @@
module tb_mmss_led_display_frame_core;
  import mmss_pkg::*;

  localparam int CYCLE_LIMIT   = 800000;
  localparam int RANDOM_ITEMS  = 390;
  localparam int HOLD_AT_BYTE  = 150;
  localparam int HOLD_CYCLES   = 200;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;

  int errors;
  int pending;
  int cycles;
  int bytes_taken;
  bit calm_sender;

  mmss_led_display_frame_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  mmss_frame_checker i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_i (s_axis_tready),
    .in_data_i  (s_axis_tdata),
    .out_valid_i(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_i (m_axis_tdata),
    .out_last_i (m_axis_tlast),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cycles        = 0;
    bytes_taken   = 0;
    calm_sender   = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** mmss_led_display_frame_core: FAILED **");
      $finish;
    end
  end

  function automatic int idle_length(input bit calm, input int long_max);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, long_max);
  endfunction

  task automatic send_time(input logic [12:0] secs, input logic [7:0] leds);
    int gap;
    gap = idle_length(calm_sender, 40);
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, leds, secs};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // receiver: random stalls, calm stretches, and one long hold-off to back up the block
  initial begin
    int  stall;
    bit  held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && bytes_taken >= HOLD_AT_BYTE) begin
        held  = 1'b1;
        stall = HOLD_CYCLES;
      end else begin
        stall = idle_length((bytes_taken / 250) % 3 == 1, 24);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      bytes_taken = bytes_taken + 1;
    end
  end

  initial begin
    int mm;
    int ss;
    int r;
    logic [12:0] secs;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // range ends, minute rollover, saturation above 99:59
    send_time(13'd0,    8'h00);
    send_time(13'd5999, 8'hff);
    send_time(13'd5998, 8'haa);
    send_time(13'd6000, 8'h55);
    send_time(13'h1fff, 8'h01);
    send_time(13'd59,   8'h80);
    send_time(13'd60,   8'h02);
    send_time(13'd3599, 8'h40);
    send_time(13'd3600, 8'h04);
    send_time(13'd4095, 8'h20);
    // every digit in every position
    for (int d = 0; d < 10; d++) begin
      mm = 10 * d + (d + 1) % 10;
      ss = ((d + 2) % 6) * 10 + (d + 3) % 10;
      send_time(13'(mm * 60 + ss), 8'(1 << (d % 8)));
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm_sender = ((n / 50) % 4 == 2);
      r = $urandom_range(0, 99);
      if (r < 85) secs = 13'($urandom_range(0, 5999));
      else if (r < 95) secs = 13'($urandom_range(5990, 6010));
      else secs = 13'($urandom_range(6001, 8191));
      send_time(secs, 8'($urandom_range(0, 255)));
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("** mmss_led_display_frame_core: PASSED **");
    end else begin
      $display("** mmss_led_display_frame_core: FAILED **");
    end
    $finish;
  end

endmodule
